FILE: design/sha2_pkg.sv
// Package: shared types, constants and round functions for the SHA-2 engine.
`timescale 1ns / 1ps
package sha2_pkg;

  localparam int WordW = 64;

  // Register indexes on the configuration port
  localparam logic [0:0] RegHashMode = 1'd0;

  // Mode codes
  localparam logic ModeSha256 = 1'b0;
  localparam logic ModeSha512 = 1'b1;

  typedef logic [WordW-1:0] word_t;

  // Control from the sequencer to the round datapath
  typedef struct packed {
    logic       load_iv;   // reload chain and working vars with initial values
    logic       start_blk; // copy chain into working vars
    logic       do_round;  // run one compression round
    logic       finish;    // add working vars into chain
    logic [6:0] rnd;       // round number
    logic       wide;      // SHA-512 when set
  } rnd_ctl_t;

  function automatic word_t init_value(input logic [2:0] idx, input logic wide);
    word_t iv;
    case (idx)
      3'd0: iv = 64'h6a09e667f3bcc908;
      3'd1: iv = 64'hbb67ae8584caa73b;
      3'd2: iv = 64'h3c6ef372fe94f82b;
      3'd3: iv = 64'ha54ff53a5f1d36f1;
      3'd4: iv = 64'h510e527fade682d1;
      3'd5: iv = 64'h9b05688c2b3e6c1f;
      3'd6: iv = 64'h1f83d9abfb41bd6b;
      default: iv = 64'h5be0cd19137e2179;
    endcase
    return wide ? iv : {32'd0, iv[63:32]};
  endfunction

  function automatic word_t round_const(input logic [6:0] t, input logic wide);
    word_t k;
    case (t)
      7'd0: k = 64'h428a2f98d728ae22;  7'd1: k = 64'h7137449123ef65cd;
      7'd2: k = 64'hb5c0fbcfec4d3b2f;  7'd3: k = 64'he9b5dba58189dbbc;
      7'd4: k = 64'h3956c25bf348b538;  7'd5: k = 64'h59f111f1b605d019;
      7'd6: k = 64'h923f82a4af194f9b;  7'd7: k = 64'hab1c5ed5da6d8118;
      7'd8: k = 64'hd807aa98a3030242;  7'd9: k = 64'h12835b0145706fbe;
      7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
      7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
      7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
      7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
      7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
      7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
      7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
      7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
      7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
      7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
      7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
      7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
      7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
      7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
      7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
      7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
      7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
      7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
      7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
      7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
      7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
      7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
      7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
      7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
      7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
      7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
      7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
      7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
      7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
      7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
      7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
      7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
      7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
      7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
      7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
      default: k = 64'd0;
    endcase
    return wide ? k : {32'd0, k[63:32]};
  endfunction

  // 32-bit rotate right held in the low half of a word
  function automatic word_t ror32(input word_t x, input int n);
    logic [31:0] v;
    v = x[31:0];
    return {32'd0, (v >> n) | (v << (32 - n))};
  endfunction

  function automatic word_t ror64(input word_t x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

endpackage

FILE: design/sha2_round.sv
// Round unit: schedule window, working variables and chaining hash.
`timescale 1ns / 1ps
module sha2_round import sha2_pkg::*; (
  input  logic     clk,
  input  rnd_ctl_t ctl,
  input  logic     push,      // shift a new word into the schedule window
  input  word_t    push_word,
  input  logic [2:0] rd_idx,
  output word_t    chain_word
);

  word_t win_r [16];
  word_t wv_r  [8];
  word_t ch_r  [8];
  word_t mask, w_t, s0, s1, w_new, e0, e1, maj, chf, t1, t2;

  // Window holds W[t..t+15] with win_r[0] = W[t]
  always_comb begin
    mask = ctl.wide ? '1 : {32'd0, 32'hffffffff};
    w_t  = win_r[0] & mask;
    if (ctl.wide) begin
      s0 = ror64(win_r[1], 1) ^ ror64(win_r[1], 8) ^ (win_r[1] >> 7);
      s1 = ror64(win_r[14], 19) ^ ror64(win_r[14], 61) ^ (win_r[14] >> 6);
      e0 = ror64(wv_r[0], 28) ^ ror64(wv_r[0], 34) ^ ror64(wv_r[0], 39);
      e1 = ror64(wv_r[4], 14) ^ ror64(wv_r[4], 18) ^ ror64(wv_r[4], 41);
    end else begin
      s0 = ror32(win_r[1], 7) ^ ror32(win_r[1], 18) ^ ((win_r[1] & mask) >> 3);
      s1 = ror32(win_r[14], 17) ^ ror32(win_r[14], 19) ^ ((win_r[14] & mask) >> 10);
      e0 = ror32(wv_r[0], 2) ^ ror32(wv_r[0], 13) ^ ror32(wv_r[0], 22);
      e1 = ror32(wv_r[4], 6) ^ ror32(wv_r[4], 11) ^ ror32(wv_r[4], 25);
    end
    w_new = (win_r[0] + s0 + win_r[9] + s1) & mask;
    maj = (wv_r[0] & wv_r[1]) ^ (wv_r[0] & wv_r[2]) ^ (wv_r[1] & wv_r[2]);
    chf = (wv_r[4] & wv_r[5]) ^ (~wv_r[4] & wv_r[6] & mask);
    t1  = (wv_r[7] + e1 + chf + w_t + round_const(ctl.rnd, ctl.wide)) & mask;
    t2  = (e0 + maj) & mask;
  end

  // Advance the schedule window
  always_ff @(posedge clk) begin
    if (push || ctl.do_round) begin
      for (int i = 0; i < 15; i++) win_r[i] <= win_r[i+1];
      win_r[15] <= push ? (push_word & mask) : w_new;
    end
  end

  // Working variables and chain
  always_ff @(posedge clk) begin
    if (ctl.load_iv) begin
      for (int i = 0; i < 8; i++) begin
        ch_r[i] <= init_value(3'(i), ctl.wide);
        wv_r[i] <= init_value(3'(i), ctl.wide);
      end
    end else if (ctl.start_blk) begin
      for (int i = 0; i < 8; i++) wv_r[i] <= ch_r[i];
    end else if (ctl.do_round) begin
      wv_r[7] <= wv_r[6];
      wv_r[6] <= wv_r[5];
      wv_r[5] <= wv_r[4];
      wv_r[4] <= (wv_r[3] + t1) & mask;
      wv_r[3] <= wv_r[2];
      wv_r[2] <= wv_r[1];
      wv_r[1] <= wv_r[0];
      wv_r[0] <= (t1 + t2) & mask;
    end else if (ctl.finish) begin
      for (int i = 0; i < 8; i++) ch_r[i] <= (ch_r[i] + wv_r[i]) & mask;
    end
  end

  assign chain_word = ch_r[rd_idx];

endmodule

FILE: design/sha2_256_512_hash_engine_unit.sv
// Top level: SHA-256/SHA-512 streaming hash engine with sequencer and ports.
`timescale 1ns / 1ps
// Usage:
//   Write hash_mode (byte address 0) over the APB-style port while idle; any
//   write restarts the message with the initial values of the new mode.
//   Feed message words on in_* (valid/ready). Words are taken one per cycle
//   unless one closes a 16-word block; then the shared round unit runs one
//   round per cycle, 64 (SHA-256) or 80 (SHA-512) rounds between a block
//   setup step and a chain update step, and in_ready is low meanwhile.
//   A word with in_end_of_message set expands into padding words (one per
//   cycle), then up to two compressions, then eight digest transactions on
//   out_* in index order, one per cycle while out_ready is high. A stalled
//   receiver holds the current digest word; no input is taken until the
//   last digest word leaves.
//   Reset (rst_n low, synchronous) selects SHA-256, loads the initial hash
//   and clears counters; the schedule window is not cleared.
module sha2_256_512_hash_engine_unit import sha2_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_message_word,
  input  logic [3:0]  in_valid_bytes,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_digest_word,
  output logic [2:0]  out_digest_index,
  output logic        out_digest_last,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_START, ST_ROUND, ST_FINISH, ST_PAD, ST_OUT, ST_INIT
  } state_t;

  state_t      state_r;
  logic        mode_r;
  logic [3:0]  words_r;
  logic [6:0]  rnd_r;
  logic [63:0] bitlen_r;
  logic        pad_r;     // padding in progress
  logic        need80_r;  // 0x80 still owed to the next word
  logic        len_ok_r;  // length words go into the current block
  logic        done_r;    // length block queued, digest follows
  logic [2:0]  oidx_r;
  rnd_ctl_t    ctl;
  logic        push;
  word_t       push_word;
  word_t       chain_word;
  logic        cfg_wr;

  logic [3:0]  vb;
  logic        is_last_rnd;
  logic        full_last;
  word_t       mask, in_w, last_w, pad_w;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr == {RegHashMode, 1'b0});
  assign cfg_prdata = (cfg_paddr == {RegHashMode, 1'b0}) ? {31'd0, mode_r} : 32'd0;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign out_digest_word  = chain_word;
  assign out_digest_index = oidx_r;
  assign out_digest_last  = (oidx_r == 3'd7);

  // Build the pushed word: data, last data with padding, or padding
  always_comb begin
    mask = mode_r ? '1 : {32'd0, 32'hffffffff};
    in_w = in_message_word & mask;
    vb   = in_valid_bytes;
    if (mode_r == ModeSha512) begin
      if (vb > 4'd8) vb = 4'd8;
    end else begin
      if (vb > 4'd4) vb = 4'd4;
    end
    full_last = mode_r ? (vb == 4'd8) : (vb == 4'd4);
    last_w = in_w & ~(mask >> {vb, 3'b000});
    if (vb == 4'd0) last_w = '0;
    if (mode_r == ModeSha512) begin
      if (vb < 4'd8) last_w = last_w | (64'h80 << {3'd7 - vb[2:0], 3'b000});
    end else begin
      if (vb < 4'd4) last_w = last_w | (64'h80 << {3'd3 - vb[2:0], 3'b000});
    end
    // padding word in the current position
    pad_w = '0;
    if (need80_r) pad_w = mode_r ? 64'h8000000000000000 : 64'h80000000;
    else if (len_ok_r && words_r == 4'd14) pad_w = mode_r ? 64'd0 : {32'd0, bitlen_r[63:32]};
    else if (len_ok_r && words_r == 4'd15) pad_w = mode_r ? bitlen_r : {32'd0, bitlen_r[31:0]};
    push = 1'b0;
    push_word = pad_w;
    if (state_r == ST_IDLE && in_valid) begin
      push = 1'b1;
      push_word = in_end_of_message ? last_w : in_w;
    end else if (state_r == ST_PAD) begin
      push = 1'b1;
    end
    is_last_rnd = mode_r ? (rnd_r == 7'd79) : (rnd_r == 7'd63);
  end

  assign ctl.load_iv   = !rst_n || cfg_wr || (state_r == ST_INIT);
  assign ctl.start_blk = (state_r == ST_START);
  assign ctl.do_round  = (state_r == ST_ROUND);
  assign ctl.finish    = (state_r == ST_FINISH);
  assign ctl.rnd       = rnd_r;
  assign ctl.wide      = rst_n ? (cfg_wr ? cfg_pwdata[0] : mode_r) : ModeSha256;

  sha2_round u_round (
    .clk        (clk),
    .ctl        (ctl),
    .push       (push),
    .push_word  (push_word),
    .rd_idx     (oidx_r),
    .chain_word (chain_word)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      mode_r   <= ModeSha256;
      words_r  <= '0;
      rnd_r    <= '0;
      bitlen_r <= '0;
      pad_r    <= 1'b0;
      need80_r <= 1'b0;
      len_ok_r <= 1'b0;
      done_r   <= 1'b0;
      oidx_r   <= '0;
    end else if (cfg_wr) begin
      state_r  <= ST_IDLE;
      mode_r   <= cfg_pwdata[0];
      words_r  <= '0;
      bitlen_r <= '0;
      pad_r    <= 1'b0;
      need80_r <= 1'b0;
      len_ok_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            words_r <= words_r + 4'd1;
            if (in_end_of_message) begin
              bitlen_r <= bitlen_r + {57'd0, vb, 3'b000};
              pad_r    <= 1'b1;
              need80_r <= full_last;
              len_ok_r <= !full_last && (words_r <= 4'd13);
            end else begin
              bitlen_r <= bitlen_r + (mode_r ? 64'd64 : 64'd32);
            end
            if (words_r == 4'd15) state_r <= ST_START;
            else if (in_end_of_message) state_r <= ST_PAD;
          end
        end
        ST_PAD: begin
          need80_r <= 1'b0;
          words_r  <= words_r + 4'd1;
          // 0x80 placed in the last two slots pushes the length to a new block
          if (need80_r) len_ok_r <= (words_r <= 4'd13);
          if (words_r == 4'd15) begin
            state_r <= ST_START;
            if (len_ok_r && !need80_r) begin
              pad_r  <= 1'b0;
              done_r <= 1'b1;
            end
          end
        end
        ST_START: begin
          rnd_r   <= '0;
          if (pad_r) len_ok_r <= 1'b1;
          state_r <= ST_ROUND;
        end
        ST_ROUND: begin
          rnd_r <= rnd_r + 7'd1;
          if (is_last_rnd) state_r <= ST_FINISH;
        end
        ST_FINISH: begin
          if (done_r) begin
            oidx_r  <= '0;
            state_r <= ST_OUT;
          end else if (pad_r) begin
            state_r <= ST_PAD;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            oidx_r <= oidx_r + 3'd1;
            if (oidx_r == 3'd7) state_r <= ST_INIT;
          end
        end
        ST_INIT: begin
          words_r  <= '0;
          bitlen_r <= '0;
          len_ok_r <= 1'b0;
          done_r   <= 1'b0;
          state_r  <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // A digest is offered only after a finished block
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r) == ST_FINISH)
    else $error("digest offered without finished block");

  // No input is taken while rounds run
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND) |-> !in_ready)
    else $error("input ready during rounds");

  // Round counter stays within the mode's round count
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND) |-> (rnd_r < (mode_r ? 7'd80 : 7'd64)))
    else $error("round counter out of range");

endmodule
